[src/delimited_line_tokenizer_unit_defines.svh]
// assertion macros for the delimited line tokenizer checker
`ifndef DELIMITED_LINE_TOKENIZER_UNIT_DEFINES_SVH
`define DELIMITED_LINE_TOKENIZER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define DLT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("dlt checker: same-cycle property failed");

// next-cycle implication, disabled while reset is low
`define DLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("dlt checker: next-cycle property failed");

`endif

[src/dlt_pkg.sv]
// types, constants and helpers shared by the delimited line tokenizer
`timescale 1ns / 1ps

package dlt_pkg;

  localparam int LINE_BUFFER = 1024;
  localparam int MAX_TOKENS  = 64;
  localparam int TOKEN_SIZE  = 128;
  localparam int FIFO_DEPTH  = 4;   // power of two

  localparam int LINE_W = $clog2(LINE_BUFFER);
  localparam int TOK_W  = $clog2(MAX_TOKENS);
  localparam int POS_W  = $clog2(TOKEN_SIZE + 1);
  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_ESCAPE = 8'h5C;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;

  localparam logic [15:0] LINE_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    KIND_CHAR  = 3'd0,
    KIND_CLOSE = 3'd1,
    KIND_FIELD = 3'd2,
    KIND_SKIP  = 3'd3,
    KIND_ERROR = 3'd4,
    KIND_END   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ERR_TOO_MANY = 2'd0,
    ERR_TOO_LONG = 2'd1,
    ERR_UNCLOSED = 2'd2,
    ERR_NO_DATA  = 2'd3
  } err_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  character;
    logic [5:0]  token_slot;
    logic [6:0]  char_position;
    logic [6:0]  token_count;
    err_e        error_code;
    logic [15:0] line_count;
    logic        stream_done;
    logic        last;
  } out_item_t;

  // one queue entry carries every result of one item
  typedef struct packed {
    out_item_t res0;
    out_item_t res1;
    logic      two;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
  endfunction

endpackage

[src/delimited_line_tokenizer_unit.sv]
// top level of the delimited line tokenizer
`timescale 1ns / 1ps

// delimited line tokenizer
// input channel: in_valid_i / in_stall_o / in_item_i, one text byte or an
//   end-of-input mark per item; an item is taken at a rising edge with
//   in_valid_i high and in_stall_o low
// output channel: out_valid_o / out_stall_i / out_item_o, one result per item
//   moved; an item yields zero, one or two results, the last one flagged
// throughput: one input item per cycle while in_stall_o is low; the front end
//   updates all line and token state in the cycle it takes a byte, so bytes
//   may follow back to back
// results leave one per cycle through the output register while out_stall_i
//   is low, so an item with two results holds the output side for both; a
//   four-entry queue between the front end and the output side absorbs such bursts
// an item's results are written to the queue at the accepting edge, and the
//   output register loads each from the queue head once it is free
// stall: while out_stall_i is high the shown result holds; the queue fills
//   and in_stall_o rises once it is full
// reset: all line state clears, the field-name token starts open, the line
//   counter is zero and the queue and output register empty; after an error
//   or the end-of-stream result the block takes items but gives no results
//   until the next reset

module delimited_line_tokenizer_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dlt_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dlt_pkg::out_item_t out_item_o
);

  logic                accept;
  logic                push, pop;
  dlt_pkg::q_entry_t   entry, head;
  dlt_pkg::fifo_stat_t stat;

  // input stalls only on a full queue
  assign in_stall_o = stat.full;
  assign accept     = in_valid_i && !in_stall_o;

  // classify bytes and update line state
  dlt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .push_o   (push),
    .entry_o  (entry)
  );

  // decouples the front end from the output stall
  dlt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (stat)
  );

  // hands results out one at a time
  dlt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .stat_i      (stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

[src/dlt_front.sv]
// front end: takes bytes, keeps line and token state, builds the results of each item
`timescale 1ns / 1ps

module dlt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  dlt_pkg::in_item_t item_i,
  output logic              push_o,
  output dlt_pkg::q_entry_t entry_o
);

  logic [dlt_pkg::LINE_W-1:0] line_length_q, line_length_d, t_ll;
  logic [dlt_pkg::TOK_W-1:0]  token_number_q, token_number_d, t_tn;
  logic [dlt_pkg::POS_W-1:0]  position_q, position_d, t_pos;
  logic                       token_open_q, token_open_d, t_open;
  logic                       escape_q, escape_d, t_esc;
  logic                       after_cr_q, after_cr_d;
  logic                       comment_q, comment_d, t_cmt;
  logic                       seen_q, seen_d, t_seen;
  logic [15:0]                lines_read_q, lines_read_d;
  logic                       halted_q, halted_d;

  logic [7:0]                 c;
  logic                       blank;
  logic [15:0]                cur_line;
  logic [dlt_pkg::TOK_W:0]    tn_inc;
  logic                       tb_v, tb_fail, do_el, el_err, end_v;
  dlt_pkg::out_item_t         tb_res, el_res, end_res, r0, r1;
  logic [1:0]                 n_res;

  function automatic dlt_pkg::out_item_t fail_res(dlt_pkg::err_e code, logic [15:0] line);
    dlt_pkg::out_item_t r;
    r             = '0;
    r.kind        = dlt_pkg::KIND_ERROR;
    r.error_code  = code;
    r.line_count  = line;
    r.stream_done = 1'b1;
    return r;
  endfunction

  function automatic dlt_pkg::out_item_t char_res(logic [7:0] ch,
      logic [dlt_pkg::TOK_W-1:0] slot, logic [dlt_pkg::POS_W-1:0] pos, logic [15:0] line);
    dlt_pkg::out_item_t r;
    r               = '0;
    r.kind          = dlt_pkg::KIND_CHAR;
    r.character     = ch;
    r.token_slot    = 6'(slot);
    r.char_position = 7'(pos);
    r.line_count    = line;
    return r;
  endfunction

  function automatic dlt_pkg::out_item_t end_line_res(logic cmt, logic seen, logic open,
      logic [dlt_pkg::TOK_W-1:0] tn, logic [15:0] line);
    dlt_pkg::out_item_t r;
    r            = '0;
    r.line_count = line;
    if (cmt || !seen) begin
      r.kind = dlt_pkg::KIND_SKIP;
    end else if (open) begin
      r = fail_res(dlt_pkg::ERR_UNCLOSED, line);
    end else if (tn == dlt_pkg::TOK_W'(1)) begin
      r = fail_res(dlt_pkg::ERR_NO_DATA, line);
    end else begin
      r.kind        = dlt_pkg::KIND_FIELD;
      r.token_count = 7'(tn);
    end
    return r;
  endfunction

  assign c        = item_i.byte_in;
  assign blank    = dlt_pkg::is_blank(c);
  assign cur_line = (lines_read_q != dlt_pkg::LINE_MAX) ? lines_read_q + 16'd1
                                                        : dlt_pkg::LINE_MAX;
  assign tn_inc   = {1'b0, token_number_q} + {{dlt_pkg::TOK_W{1'b0}}, 1'b1};

  // per-byte line handling, then line end, then end of stream
  always_comb begin
    t_ll    = line_length_q;
    t_tn    = token_number_q;
    t_pos   = position_q;
    t_open  = token_open_q;
    t_esc   = escape_q;
    t_cmt   = comment_q;
    t_seen  = seen_q;
    tb_v    = 1'b0;
    tb_fail = 1'b0;
    tb_res  = '0;
    do_el   = 1'b0;
    end_v   = 1'b0;
    after_cr_d = after_cr_q;

    if (accept_i && !halted_q) begin
      if (item_i.end_of_input) begin
        after_cr_d = 1'b0;
        do_el      = (line_length_q != '0);
      end else if (c == dlt_pkg::CH_CR) begin
        after_cr_d = 1'b1;
        do_el      = 1'b1;
      end else if (c == dlt_pkg::CH_LF) begin
        if (after_cr_q) begin
          after_cr_d = 1'b0;
        end else begin
          do_el = 1'b1;
        end
      end else begin
        after_cr_d = 1'b0;
        t_cmt = comment_q || ((line_length_q == '0) && (c == dlt_pkg::CH_HASH));
        t_ll  = line_length_q + dlt_pkg::LINE_W'(1);
        if (t_cmt) begin
          // rest of a comment line is dropped
        end else if (!seen_q && blank) begin
          if (position_q < dlt_pkg::POS_W'(dlt_pkg::TOKEN_SIZE - 1)) begin
            tb_v   = 1'b1;
            tb_res = char_res(c, token_number_q, position_q, cur_line);
          end
          if (position_q < dlt_pkg::POS_W'(dlt_pkg::TOKEN_SIZE)) begin
            t_pos = position_q + dlt_pkg::POS_W'(1);
          end
        end else begin
          t_seen = 1'b1;
          if (!seen_q && (position_q > dlt_pkg::POS_W'(dlt_pkg::TOKEN_SIZE - 1))) begin
            tb_fail = 1'b1;
            tb_res  = fail_res(dlt_pkg::ERR_TOO_LONG, cur_line);
          end else if (escape_q || ((c != dlt_pkg::CH_ESCAPE) && (c != dlt_pkg::CH_COLON)))
          begin
            t_esc = 1'b0;
            if (!token_open_q && !blank) begin
              t_open = 1'b1;
            end
            if (position_q >= dlt_pkg::POS_W'(dlt_pkg::TOKEN_SIZE - 1)) begin
              tb_fail = 1'b1;
              tb_res  = fail_res(dlt_pkg::ERR_TOO_LONG, cur_line);
            end else begin
              tb_v   = 1'b1;
              tb_res = char_res(c, token_number_q, position_q, cur_line);
              t_pos  = position_q + dlt_pkg::POS_W'(1);
            end
          end else if (c == dlt_pkg::CH_ESCAPE) begin
            t_esc = 1'b1;
          end else begin
            // colon closes the token
            if (token_number_q == dlt_pkg::TOK_W'(dlt_pkg::MAX_TOKENS - 1)) begin
              tb_fail = 1'b1;
              tb_res  = fail_res(dlt_pkg::ERR_TOO_MANY, cur_line);
            end else begin
              tb_v                 = 1'b1;
              tb_res               = '0;
              tb_res.kind          = dlt_pkg::KIND_CLOSE;
              tb_res.token_slot    = 6'(token_number_q);
              tb_res.char_position = 7'(position_q);
              tb_res.token_count   = 7'(tn_inc);
              tb_res.line_count    = cur_line;
              t_tn                 = dlt_pkg::TOK_W'(tn_inc);
              t_pos                = '0;
              t_open               = 1'b0;
            end
          end
        end
        // full line buffer splits the line
        do_el = !tb_fail && (t_ll >= dlt_pkg::LINE_W'(dlt_pkg::LINE_BUFFER - 1));
      end
    end

    el_res = end_line_res(t_cmt, t_seen, t_open, t_tn, cur_line);
    el_err = do_el && (el_res.kind == dlt_pkg::KIND_ERROR);

    end_res            = '0;
    end_res.kind       = dlt_pkg::KIND_END;
    end_res.line_count = do_el ? cur_line : lines_read_q;
    end_res.stream_done = 1'b1;
    end_v = accept_i && !halted_q && item_i.end_of_input && !el_err;
  end

  // next state
  always_comb begin
    line_length_d  = t_ll;
    token_number_d = t_tn;
    position_d     = t_pos;
    token_open_d   = t_open;
    escape_d       = t_esc;
    comment_d      = t_cmt;
    seen_d         = t_seen;
    lines_read_d   = lines_read_q;
    halted_d       = halted_q || tb_fail || el_err ||
                     (accept_i && item_i.end_of_input);
    if (do_el) begin
      lines_read_d   = cur_line;
      line_length_d  = '0;
      token_number_d = '0;
      position_d     = '0;
      token_open_d   = 1'b1;
      escape_d       = 1'b0;
      comment_d      = 1'b0;
      seen_d         = 1'b0;
    end
  end

  // result packing, in the order byte result, line end, stream end
  always_comb begin
    r0    = '0;
    r1    = '0;
    n_res = 2'd0;
    if (tb_v || tb_fail) begin
      r0 = tb_res;
      if (do_el) begin
        r1    = el_res;
        n_res = 2'd2;
      end else begin
        n_res = 2'd1;
      end
    end else if (do_el) begin
      r0 = el_res;
      if (end_v) begin
        r1    = end_res;
        n_res = 2'd2;
      end else begin
        n_res = 2'd1;
      end
    end else if (end_v) begin
      r0    = end_res;
      n_res = 2'd1;
    end
    if (n_res == 2'd2) begin
      r1.last = 1'b1;
    end else begin
      r0.last = 1'b1;
    end
  end

  assign push_o        = (n_res != 2'd0);
  assign entry_o.res0  = r0;
  assign entry_o.res1  = r1;
  assign entry_o.two   = (n_res == 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q  <= '0;
      token_number_q <= '0;
      position_q     <= '0;
      token_open_q   <= 1'b1;
      escape_q       <= 1'b0;
      after_cr_q     <= 1'b0;
      comment_q      <= 1'b0;
      seen_q         <= 1'b0;
      lines_read_q   <= '0;
      halted_q       <= 1'b0;
    end else begin
      line_length_q  <= line_length_d;
      token_number_q <= token_number_d;
      position_q     <= position_d;
      token_open_q   <= token_open_d;
      escape_q       <= escape_d;
      after_cr_q     <= after_cr_d;
      comment_q      <= comment_d;
      seen_q         <= seen_d;
      lines_read_q   <= lines_read_d;
      halted_q       <= halted_d;
    end
  end

endmodule

[src/dlt_queue.sv]
// short flop queue between front end and output side
`timescale 1ns / 1ps

module dlt_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dlt_pkg::q_entry_t   entry_i,
  input  logic                pop_i,
  output dlt_pkg::q_entry_t   head_o,
  output dlt_pkg::fifo_stat_t stat_o
);

  dlt_pkg::q_entry_t         mem_q [dlt_pkg::FIFO_DEPTH];
  logic [dlt_pkg::PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [dlt_pkg::CNT_W-1:0] count_q, count_d;
  logic                      do_push, do_pop;

  assign stat_o.full  = (count_q == dlt_pkg::CNT_W'(dlt_pkg::FIFO_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + dlt_pkg::PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + dlt_pkg::PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + dlt_pkg::CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - dlt_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[src/dlt_back.sv]
// output side: splits queue entries into single results behind an output register
`timescale 1ns / 1ps

module dlt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dlt_pkg::q_entry_t   head_i,
  input  dlt_pkg::fifo_stat_t stat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dlt_pkg::out_item_t  out_item_o
);

  logic               out_valid_q, out_valid_d;
  logic               phase_q, phase_d;
  dlt_pkg::out_item_t out_item_q;
  logic               load_ok, take;

  assign load_ok = !out_valid_q || !out_stall_i;
  assign take    = load_ok && !stat_i.empty;

  always_comb begin
    out_valid_d = load_ok ? !stat_i.empty : out_valid_q;
    pop_o       = take && (phase_q || !head_i.two);
    phase_d     = take ? (head_i.two && !phase_q) : phase_q;
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_item_q <= phase_q ? head_i.res1 : head_i.res0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[src/dlt_checker.sv]
// port-level checker for the delimited line tokenizer and its bind
`timescale 1ns / 1ps
`include "delimited_line_tokenizer_unit_defines.svh"

module dlt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input dlt_pkg::out_item_t out_item_o
);

  // a stalled result holds
  `DLT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))

  // nothing follows the result that ends the stream
  `DLT_ASSERT_NEXT(a_done_quiet, clk_i, rst_ni, out_valid_o && !out_stall_i && out_item_o.stream_done, !out_valid_o)

  // error and end results end the stream and close their item
  `DLT_ASSERT_IMPLY(a_end_kinds, clk_i, rst_ni, out_valid_o && (out_item_o.kind == dlt_pkg::KIND_ERROR || out_item_o.kind == dlt_pkg::KIND_END), out_item_o.stream_done && out_item_o.last)

  // token characters carry no count and never end the stream
  `DLT_ASSERT_IMPLY(a_char_fields, clk_i, rst_ni, out_valid_o && (out_item_o.kind == dlt_pkg::KIND_CHAR), !out_item_o.stream_done && (out_item_o.token_count == 7'd0))

endmodule

bind delimited_line_tokenizer_unit dlt_checker u_dlt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

[sim/delimited_line_tokenizer_unit_tb.sv]
// self-checking testbench for the delimited line tokenizer unit
`timescale 1ns / 1ps

module delimited_line_tokenizer_unit_tb;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned DRAIN_LIMIT = 50_000;
  localparam int unsigned TAIL_CYCLES = 16;
  localparam int unsigned RANDOM_ITEMS = 200;
  // error_code reads zero outside error results
  localparam dlt_pkg::err_e NO_ERR_CODE = dlt_pkg::ERR_TOO_MANY;

  typedef enum {TERM_LF, TERM_CR, TERM_CRLF} term_e;
  typedef enum {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;
  typedef enum {
    END_TOO_MANY, END_TOO_LONG, END_LONG_LEAD, END_UNCLOSED, END_NO_DATA,
    END_AT_BOUNDARY, END_MID_LINE
  } ending_e;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  dlt_pkg::in_item_t  in_item_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  dlt_pkg::out_item_t out_item_o;

  delimited_line_tokenizer_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // tokenizer state mirror and the results it predicts
  // ---------------------------------------------------------------------------
  int unsigned        ln_len, tok_num, tok_pos, lines_rd;
  bit                 tok_open, esc_pend, after_cr, in_comment, seen_data, halted;
  dlt_pkg::out_item_t step_res [2];
  int unsigned        step_n;
  dlt_pkg::out_item_t due_results [$];

  int unsigned        mismatch_count = 0;
  int unsigned        cycle_count = 0;
  int unsigned        items_sent = 0;
  int unsigned        burst_left = 0;
  int unsigned        gap_len;
  dlt_pkg::out_item_t want_res;
  stall_mode_e        stall_mode = STALL_NONE;
  int unsigned        stall_left = 0;

  function automatic bit blank_char(logic [7:0] c);
    return c == dlt_pkg::CH_SPACE || c == dlt_pkg::CH_TAB ||
           c == dlt_pkg::CH_VT || c == dlt_pkg::CH_FF;
  endfunction

  function automatic int unsigned line_now();
    return (lines_rd < dlt_pkg::LINE_MAX) ? lines_rd + 1 : dlt_pkg::LINE_MAX;
  endfunction

  function automatic void add_res(dlt_pkg::kind_e k, logic [7:0] ch, int unsigned slot,
                                  int unsigned pos, int unsigned cnt,
                                  dlt_pkg::err_e code, int unsigned line, bit done);
    if (step_n >= 2) return;
    step_res[step_n] = '{kind: k, character: ch, token_slot: slot[5:0],
                         char_position: pos[6:0], token_count: cnt[6:0],
                         error_code: code, line_count: line[15:0],
                         stream_done: done, last: 1'b0};
    step_n++;
  endfunction

  function automatic void raise_error(dlt_pkg::err_e code, int unsigned line);
    add_res(dlt_pkg::KIND_ERROR, 8'h00, 0, 0, 0, code, line, 1'b1);
    halted = 1'b1;
  endfunction

  function automatic void new_line();
    ln_len     = 0;
    tok_num    = 0;
    tok_pos    = 0;
    tok_open   = 1'b1;
    esc_pend   = 1'b0;
    in_comment = 1'b0;
    seen_data  = 1'b0;
  endfunction

  function automatic void reset_model();
    new_line();
    after_cr = 1'b0;
    lines_rd = 0;
    halted   = 1'b0;
  endfunction

  function automatic void finish_line();
    if (lines_rd < dlt_pkg::LINE_MAX) lines_rd++;
    if (in_comment || !seen_data) begin
      add_res(dlt_pkg::KIND_SKIP, 8'h00, 0, 0, 0, NO_ERR_CODE, lines_rd, 1'b0);
    end else if (tok_open) begin
      raise_error(dlt_pkg::ERR_UNCLOSED, lines_rd);
    end else if (tok_num == 1) begin
      raise_error(dlt_pkg::ERR_NO_DATA, lines_rd);
    end else begin
      add_res(dlt_pkg::KIND_FIELD, 8'h00, 0, 0, tok_num, NO_ERR_CODE, lines_rd, 1'b0);
    end
    new_line();
  endfunction

  function automatic void put_char(logic [7:0] c);
    // blanks never open a token, anything else does
    if (!tok_open && !blank_char(c)) tok_open = 1'b1;
    if (tok_pos >= dlt_pkg::TOKEN_SIZE - 1) begin
      raise_error(dlt_pkg::ERR_TOO_LONG, line_now());
      return;
    end
    add_res(dlt_pkg::KIND_CHAR, c, tok_num, tok_pos, 0, NO_ERR_CODE, line_now(), 1'b0);
    tok_pos++;
  endfunction

  function automatic void close_tok();
    if (tok_num + 1 >= dlt_pkg::MAX_TOKENS) begin
      raise_error(dlt_pkg::ERR_TOO_MANY, line_now());
      return;
    end
    add_res(dlt_pkg::KIND_CLOSE, 8'h00, tok_num, tok_pos, tok_num + 1, NO_ERR_CODE,
            line_now(), 1'b0);
    tok_num++;
    tok_pos  = 0;
    tok_open = 1'b0;
  endfunction

  function automatic void take_text_byte(logic [7:0] c);
    if (ln_len == 0 && c == dlt_pkg::CH_HASH) in_comment = 1'b1;
    ln_len++;
    if (!in_comment) begin
      if (!seen_data && blank_char(c)) begin
        // whitespace lead-in: shown while it fits, counted up to the limit
        if (tok_pos < dlt_pkg::TOKEN_SIZE - 1)
          add_res(dlt_pkg::KIND_CHAR, c, tok_num, tok_pos, 0, NO_ERR_CODE,
                  line_now(), 1'b0);
        if (tok_pos < dlt_pkg::TOKEN_SIZE) tok_pos++;
      end else begin
        if (!seen_data) begin
          seen_data = 1'b1;
          if (tok_pos > dlt_pkg::TOKEN_SIZE - 1) begin
            raise_error(dlt_pkg::ERR_TOO_LONG, line_now());
            return;
          end
        end
        if (esc_pend) begin
          esc_pend = 1'b0;
          put_char(c);
        end else if (c == dlt_pkg::CH_ESCAPE) begin
          esc_pend = 1'b1;
        end else if (c == dlt_pkg::CH_COLON) begin
          close_tok();
        end else begin
          put_char(c);
        end
      end
    end
    // a full line buffer ends the line here
    if (!halted && ln_len >= dlt_pkg::LINE_BUFFER - 1) finish_line();
  endfunction

  function automatic void tokenize_item(dlt_pkg::in_item_t it);
    step_n = 0;
    if (halted) return;
    if (it.end_of_input) begin
      after_cr = 1'b0;
      if (ln_len > 0) finish_line();
      if (!halted) begin
        add_res(dlt_pkg::KIND_END, 8'h00, 0, 0, 0, NO_ERR_CODE, lines_rd, 1'b1);
        halted = 1'b1;
      end
    end else if (it.byte_in == dlt_pkg::CH_CR) begin
      after_cr = 1'b1;
      finish_line();
    end else if (it.byte_in == dlt_pkg::CH_LF) begin
      // LF right after CR belongs to the same line end
      if (after_cr) after_cr = 1'b0;
      else finish_line();
    end else begin
      after_cr = 1'b0;
      take_text_byte(it.byte_in);
    end
    for (int i = 0; i < step_n; i++) begin
      if (i == step_n - 1) step_res[i].last = 1'b1;
      due_results.push_back(step_res[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  function automatic string fmt_res(dlt_pkg::out_item_t r);
    return {$sformatf("kind=%0d char=%02h slot=%0d pos=%0d cnt=%0d ",
                      r.kind, r.character, r.token_slot, r.char_position,
                      r.token_count),
            $sformatf("err=%0d line=%0d done=%0b last=%0b",
                      r.error_code, r.line_count, r.stream_done, r.last)};
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", what);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        report_mismatch({"result with nothing expected: ", fmt_res(out_item_o)});
      end else begin
        want_res = due_results.pop_front();
        if (out_item_o.kind !== want_res.kind ||
            out_item_o.character !== want_res.character ||
            out_item_o.token_slot !== want_res.token_slot ||
            out_item_o.char_position !== want_res.char_position ||
            out_item_o.token_count !== want_res.token_count ||
            out_item_o.error_code !== want_res.error_code ||
            out_item_o.line_count !== want_res.line_count ||
            out_item_o.stream_done !== want_res.stream_done ||
            out_item_o.last !== want_res.last)
          report_mismatch($sformatf("result mismatch\n  expected %s\n  actual   %s",
                                    fmt_res(want_res), fmt_res(out_item_o)));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("delimited_line_tokenizer_unit regression: fail");
      $finish;
    end
  end

  // receiver stalls in phases of its own
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:     out_stall_i <= 1'b0;
      STALL_SPARSE:   out_stall_i <= ($urandom_range(0, 99) < 30);
      STALL_PERIODIC: out_stall_i <= (stall_left % 3 == 0);
      default:        out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // sending items
  // ---------------------------------------------------------------------------
  task automatic send_item(input dlt_pkg::in_item_t it);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        gap_len    = 0;
        burst_left = $urandom_range(50, 200);
      end else begin
        gap_len    = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 24);
      end
      repeat (gap_len) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    items_sent++;
    tokenize_item(it);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(dlt_pkg::in_item_t'{byte_in: b, end_of_input: 1'b0});
  endtask

  task automatic send_eoi();
    send_item(dlt_pkg::in_item_t'{byte_in: 8'($urandom), end_of_input: 1'b1});
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_run(input logic [7:0] b, input int unsigned n);
    repeat (n) send_byte(b);
  endtask

  task automatic send_terminator(input term_e t);
    case (t)
      TERM_LF: send_byte(dlt_pkg::CH_LF);
      TERM_CR: send_byte(dlt_pkg::CH_CR);
      default: begin
        send_byte(dlt_pkg::CH_CR);
        send_byte(dlt_pkg::CH_LF);
      end
    endcase
  endtask

  task automatic wait_drained();
    int unsigned n;
    n = 0;
    while (due_results.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
  endtask

  task automatic pause_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    wait_drained();
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // random line content
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] rand_byte(bit plain, bit lead);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == dlt_pkg::CH_CR || b == dlt_pkg::CH_LF ||
               (plain && (b == dlt_pkg::CH_COLON || b == dlt_pkg::CH_ESCAPE)) ||
               (lead && (blank_char(b) || b == dlt_pkg::CH_HASH)));
    return b;
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 3))
      0:       return dlt_pkg::CH_SPACE;
      1:       return dlt_pkg::CH_TAB;
      2:       return dlt_pkg::CH_VT;
      default: return dlt_pkg::CH_FF;
    endcase
  endfunction

  task automatic send_token_chars(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) begin
        send_byte(dlt_pkg::CH_ESCAPE);
        send_byte(rand_byte(1'b0, 1'b0));
      end else begin
        send_byte(rand_byte(1'b1, 1'b0));
      end
    end
  endtask

  // well-formed field line with random content
  task automatic send_data_line();
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) send_byte(rand_blank());
    send_byte(rand_byte(1'b1, 1'b1));
    send_token_chars($urandom_range(0, 6));
    send_byte(dlt_pkg::CH_COLON);
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) send_byte(rand_blank());
      send_token_chars($urandom_range(0, 12));
      send_byte(dlt_pkg::CH_COLON);
    end
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) send_byte(rand_blank());
    if ($urandom_range(0, 19) == 0) send_byte(dlt_pkg::CH_ESCAPE);
    send_terminator(term_e'($urandom_range(0, 2)));
  endtask

  task automatic send_random_line();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      send_data_line();
    end else if (pick < 80) begin
      send_byte(dlt_pkg::CH_HASH);
      repeat ($urandom_range(0, 20)) send_byte(rand_byte(1'b0, 1'b0));
      send_terminator(term_e'($urandom_range(0, 2)));
    end else if (pick < 90) begin
      repeat ($urandom_range(0, 10)) send_byte(rand_blank());
      send_terminator(term_e'($urandom_range(0, 2)));
    end else begin
      // stray line ends: empty lines and lone CR or LF
      repeat ($urandom_range(1, 3))
        send_byte($urandom_range(0, 1) ? dlt_pkg::CH_CR : dlt_pkg::CH_LF);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_basic_fields();
    send_text("name:value:");
    send_terminator(TERM_LF);
    send_text("k::");                 // empty data token still closes
    send_terminator(TERM_CRLF);
    send_text("a:b:c:d:");
    send_terminator(TERM_CR);
    send_text("x:y:  ");              // trailing blanks do not open a token
    send_terminator(TERM_LF);
  endtask

  task automatic test_skipped_lines();
    send_text("# comment : \\ x");
    send_terminator(TERM_LF);
    send_byte(dlt_pkg::CH_HASH);
    send_terminator(TERM_CR);
    send_byte(dlt_pkg::CH_SPACE);
    send_byte(dlt_pkg::CH_TAB);
    send_byte(dlt_pkg::CH_VT);
    send_byte(dlt_pkg::CH_FF);
    send_terminator(TERM_LF);
    send_run(dlt_pkg::CH_SPACE, 130); // lead-in counter saturates, line still skipped
    send_terminator(TERM_LF);
    send_terminator(TERM_LF);
    send_terminator(TERM_CR);
  endtask

  task automatic test_escapes();
    send_text("k\\:ey:va\\\\l\\ue:");
    send_terminator(TERM_LF);
    send_text("\\#a:b:");             // escaped hash at line start is data
    send_terminator(TERM_LF);
    send_text("a:b:\\");              // dangling escape dropped at line end
    send_terminator(TERM_LF);
    send_text("a:b:\\");
    send_terminator(TERM_CRLF);
  endtask

  task automatic test_whitespace();
    send_byte(dlt_pkg::CH_SPACE);
    send_byte(dlt_pkg::CH_TAB);
    send_text("name:val:");
    send_terminator(TERM_LF);
    send_text("n: v : w:");           // stray blanks land in the next slot
    send_terminator(TERM_LF);
    send_text("n:");
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h7F);
    send_text(":");
    send_terminator(TERM_LF);
  endtask

  task automatic test_limits();
    send_text("n");
    send_run(dlt_pkg::CH_COLON, 63);  // most tokens per field
    send_terminator(TERM_LF);
    // longest lead-in that still fits, longest tokens, and the last colon
    // fills the line buffer, then an empty line
    send_run(dlt_pkg::CH_TAB, 126);
    send_text("n:");
    repeat (6) begin
      send_run("d", 127);
      send_text(":");
    end
    send_run("e", 126);
    send_text(":");
    send_terminator(TERM_LF);
  endtask

  task automatic test_random_lines();
    int unsigned start, next_pause;
    start      = items_sent;
    next_pause = start + RANDOM_ITEMS / 2;
    while (items_sent - start < RANDOM_ITEMS) begin
      send_random_line();
      if (items_sent >= next_pause) begin
        pause_until_drained();
        next_pause = items_sent + RANDOM_ITEMS;
      end
    end
  endtask

  // one ending per run, since any error or end of stream holds until reset
  task automatic test_halting_end();
    ending_e pick;
    pick = ending_e'($urandom_range(0, 6));
    case (pick)
      END_TOO_MANY: begin
        send_text("f");
        send_run(dlt_pkg::CH_COLON, 64);
        send_terminator(TERM_LF);
      end
      END_TOO_LONG: begin
        send_text("n:");
        send_run("a", 128);
        send_text(":");
        send_terminator(TERM_LF);
      end
      END_LONG_LEAD: begin
        send_run(dlt_pkg::CH_SPACE, 130);
        send_text("x:y:");
        send_terminator(TERM_LF);
      end
      END_UNCLOSED: begin
        send_text("a:b");
        send_terminator(TERM_LF);
      end
      END_NO_DATA: begin
        send_text("a:");
        send_terminator(TERM_CRLF);
      end
      END_AT_BOUNDARY: send_eoi();
      default: begin
        case ($urandom_range(0, 2))
          0:       send_text("a:b:");
          1:       send_text("#tail");
          default: send_text("a:b");
        endcase
        send_eoi();
      end
    endcase
    // halted: nothing more comes out
    repeat (20)
      send_item(dlt_pkg::in_item_t'{byte_in: 8'($urandom), end_of_input: 1'($urandom)});
  endtask

  initial begin
    reset_model();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_fields();
    test_skipped_lines();
    test_escapes();
    test_whitespace();
    test_limits();
    pause_until_drained();
    test_random_lines();
    test_halting_end();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived, oldest %s",
                                due_results.size(), fmt_res(due_results[0])));
    if (mismatch_count == 0) begin
      $display("delimited_line_tokenizer_unit regression: pass");
    end else begin
      $display("delimited_line_tokenizer_unit regression: fail");
    end
    $finish;
  end

endmodule
